// ===== rtl/bdcs_pkg.sv =====
// Package for the button debounce and click series unit.
// Holds field widths, register indexes, reset values and the phase and edge codes.
// No dependencies.
package bdcs_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int THRESH_W  = 16;
    localparam int CLICK_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;

    localparam logic [CLICK_W-1:0] CLICK_LIMIT = 8'hFF;

    localparam logic [THRESH_W-1:0] PRESS_DEBOUNCE_RESET   = 16'd20;
    localparam logic [THRESH_W-1:0] RELEASE_DEBOUNCE_RESET = 16'd20;
    localparam logic [THRESH_W-1:0] MAX_PRESS_RESET        = 16'd2000;
    localparam logic [THRESH_W-1:0] SERIES_GAP_RESET       = 16'd500;
    localparam logic [CLICK_W-1:0]  CLICKS_CAP_RESET       = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_DEBOUNCE   = 3'd0,
        CFG_RELEASE_DEBOUNCE = 3'd1,
        CFG_MAX_PRESS        = 3'd2,
        CFG_SERIES_GAP       = 3'd3,
        CFG_CLICKS_CAP       = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PHASE_IDLE     = 2'd0,
        PHASE_COUNTING = 2'd1,
        PHASE_DISCARD  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EDGE_NONE    = 2'd0,
        EDGE_PRESS   = 2'd1,
        EDGE_RELEASE = 2'd2
    } edge_t;

endpackage

// ===== rtl/button_debounce_click_series_unit.sv =====
// Top level of the button debounce and click series unit.
// Depends on bdcs_pkg for widths, register indexes and state codes.
//
// One tick item per clock while s_tready is high: each accepted item runs the debouncer,
// the click series machine and the read-and-clear of the pending result combinationally,
// and its result enters a two-entry output stage (output register plus skid register), so
// s_tready stays high while one result waits downstream. The timer counters saturate at
// 2^TIMER_BITS - 1 and the click counter at 255. Configuration writes are taken every
// cycle and apply to the next item.
module button_debounce_click_series_unit #(
    parameter int TIMER_BITS = bdcs_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] raw_pressed, [1] listen, [2] take_result, [7:3] zero
    input  logic [bdcs_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] pressed, [2:1] edge_res, [4:3] phase, [5] series_done, [13:6] read_value,
    // [15:14] zero
    output logic [bdcs_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bdcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdcs_pkg::THRESH_W-1:0]  cfg_data
);
    import bdcs_pkg::*;

    localparam int CMP_W = (TIMER_BITS > THRESH_W) ? TIMER_BITS : THRESH_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [THRESH_W-1:0] press_deb_reg;
    logic [THRESH_W-1:0] release_deb_reg;
    logic [THRESH_W-1:0] max_press_reg;
    logic [THRESH_W-1:0] series_gap_reg;
    logic [CLICK_W-1:0]  clicks_cap_reg;

    logic                  stable_reg, stable_next;
    logic [TIMER_BITS-1:0] deb_cnt_reg, deb_cnt_next;
    logic [TIMER_BITS-1:0] press_cnt_reg, press_cnt_next;
    logic [TIMER_BITS-1:0] gap_cnt_reg, gap_cnt_next;
    logic [CLICK_W-1:0]    click_reg, click_next;
    phase_t                phase_reg, phase_next;
    logic [CLICK_W-1:0]    pending_reg, pending_next;

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic [M_DATA_W-1:0] skid_data_reg, skid_data_next;

    logic                  raw, listen, take;
    logic                  accept;
    edge_t                 edge_res;
    logic                  done;
    logic [CLICK_W-1:0]    rd_value;
    logic [THRESH_W-1:0]   deb_limit;
    logic [TIMER_BITS-1:0] deb_inc, press_inc, gap_inc;
    logic [M_DATA_W-1:0]   result;

    assign raw    = s_tdata[0];
    assign listen = s_tdata[1];
    assign take   = s_tdata[2];

    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign deb_limit = stable_reg ? release_deb_reg : press_deb_reg;
    assign deb_inc   = (deb_cnt_reg == TIMER_MAX) ? TIMER_MAX : deb_cnt_reg + 1'b1;
    assign press_inc = (press_cnt_reg == TIMER_MAX) ? TIMER_MAX : press_cnt_reg + 1'b1;
    assign gap_inc   = (gap_cnt_reg == TIMER_MAX) ? TIMER_MAX : gap_cnt_reg + 1'b1;

    always_comb
    begin
        stable_next    = stable_reg;
        deb_cnt_next   = deb_cnt_reg;
        press_cnt_next = press_cnt_reg;
        gap_cnt_next   = gap_cnt_reg;
        click_next     = click_reg;
        phase_next     = phase_reg;
        pending_next   = pending_reg;
        edge_res       = EDGE_NONE;
        done           = 1'b0;
        rd_value       = '0;

        // debounce
        if (raw == stable_reg)
        begin
            deb_cnt_next = '0;
        end
        else if (CMP_W'(deb_inc) < CMP_W'(deb_limit))
        begin
            deb_cnt_next = deb_inc;
        end
        else
        begin
            deb_cnt_next = '0;
            stable_next  = raw;
            edge_res     = raw ? EDGE_PRESS : EDGE_RELEASE;
        end

        // series machine or park
        if (!listen)
        begin
            phase_next     = stable_next ? PHASE_DISCARD : PHASE_IDLE;
            click_next     = '0;
            press_cnt_next = '0;
            gap_cnt_next   = '0;
            pending_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PHASE_IDLE:
                begin
                    if (edge_res == EDGE_PRESS)
                    begin
                        click_next     = '0;
                        press_cnt_next = '0;
                        phase_next     = PHASE_COUNTING;
                    end
                end
                PHASE_COUNTING:
                begin
                    priority if (edge_res == EDGE_RELEASE)
                    begin
                        if (click_reg != CLICK_LIMIT)
                        begin
                            click_next = click_reg + 1'b1;
                        end
                        gap_cnt_next = '0;
                    end
                    else if (edge_res == EDGE_PRESS)
                    begin
                        press_cnt_next = '0;
                    end
                    else if (stable_next)
                    begin
                        press_cnt_next = press_inc;
                        if (CMP_W'(press_inc) >= CMP_W'(max_press_reg))
                        begin
                            click_next = '0;
                            phase_next = PHASE_DISCARD;
                        end
                    end
                    else
                    begin
                        gap_cnt_next = gap_inc;
                        if (CMP_W'(gap_inc) >= CMP_W'(series_gap_reg))
                        begin
                            pending_next = (click_reg > clicks_cap_reg) ? clicks_cap_reg
                                                                        : click_reg;
                            click_next   = '0;
                            phase_next   = PHASE_IDLE;
                            done         = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (edge_res == EDGE_RELEASE)
                    begin
                        click_next = '0;
                        phase_next = PHASE_IDLE;
                    end
                end
            endcase
        end

        // read and clear
        if (take)
        begin
            rd_value     = pending_next;
            pending_next = '0;
        end
    end

    assign result = {2'b00, rd_value, done, phase_next, edge_res, stable_next};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_deb_reg   <= PRESS_DEBOUNCE_RESET;
            release_deb_reg <= RELEASE_DEBOUNCE_RESET;
            max_press_reg   <= MAX_PRESS_RESET;
            series_gap_reg  <= SERIES_GAP_RESET;
            clicks_cap_reg  <= CLICKS_CAP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PRESS_DEBOUNCE:   press_deb_reg   <= cfg_data;
                CFG_RELEASE_DEBOUNCE: release_deb_reg <= cfg_data;
                CFG_MAX_PRESS:        max_press_reg   <= cfg_data;
                CFG_SERIES_GAP:       series_gap_reg  <= cfg_data;
                CFG_CLICKS_CAP:       clicks_cap_reg  <= cfg_data[CLICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg    <= 1'b0;
            deb_cnt_reg   <= '0;
            press_cnt_reg <= '0;
            gap_cnt_reg   <= '0;
            click_reg     <= '0;
            phase_reg     <= PHASE_IDLE;
            pending_reg   <= '0;
        end
        else if (accept)
        begin
            stable_reg    <= stable_next;
            deb_cnt_reg   <= deb_cnt_next;
            press_cnt_reg <= press_cnt_next;
            gap_cnt_reg   <= gap_cnt_next;
            click_reg     <= click_next;
            phase_reg     <= phase_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
